/* rtl/core/pin_retry_lockout_table_defines.svh */
// assertion macros for the pin retry lockout table
`ifndef PIN_RETRY_LOCKOUT_TABLE_DEFINES_SVH
`define PIN_RETRY_LOCKOUT_TABLE_DEFINES_SVH

// clocked check, off while reset is asserted
`define PRLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also runs through reset
`define PRLT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/prlt_pkg.sv */
// types and constants of the pin retry lockout table
package prlt_pkg;

  localparam int unsigned CodeW = 64;

  // operation codes
  localparam logic [2:0] OpCreate  = 3'd0;
  localparam logic [2:0] OpVerify  = 3'd1;
  localparam logic [2:0] OpEnable  = 3'd2;
  localparam logic [2:0] OpDisable = 3'd3;
  localparam logic [2:0] OpUnblock = 3'd4;
  localparam logic [2:0] OpChange  = 3'd5;
  localparam logic [2:0] OpGetStat = 3'd6;
  localparam logic [2:0] OpSetStat = 3'd7;

  // result codes
  localparam logic [2:0] RcOk     = 3'd0;
  localparam logic [2:0] RcParam  = 3'd1;
  localparam logic [2:0] RcStatus = 3'd2;
  localparam logic [2:0] RcLast   = 3'd3;
  localparam logic [2:0] RcDenied = 3'd4;

  // flag bits
  localparam int unsigned FlagEnabledBit  = 0;
  localparam int unsigned FlagVerifiedBit = 1;
  localparam int unsigned FlagBlockedBit  = 2;
  localparam logic [3:0]  FlagUninit      = 4'b1000;

  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       slot;
    logic [CodeW-1:0] code_a;
    logic [CodeW-1:0] code_b;
    logic [3:0]       pin_limit_in;
    logic [3:0]       puk_limit_in;
    logic [3:0]       status_in;
  } cmd_t;

  typedef struct packed {
    logic [2:0] result_code;
    logic [3:0] status_out;
  } res_t;

  // per-slot flags and counters, kept in one memory row
  typedef struct packed {
    logic [3:0] flags;
    logic [3:0] pin_tries;
    logic [3:0] pin_limit;
    logic [3:0] puk_tries;
    logic [3:0] puk_limit;
  } meta_t;

  // per-slot secrets, kept in a second memory row
  typedef struct packed {
    logic [CodeW-1:0] pin;
    logic [CodeW-1:0] puk;
  } codes_t;

  localparam meta_t MetaReset = '{flags: FlagUninit, default: '0};

endpackage

/* rtl/core/pin_retry_lockout_table.sv */
// pin retry lockout table top level
`include "pin_retry_lockout_table_defines.svh"

// Table of SLOT_COUNT cardholder PIN slots (slot numbers 1..SLOT_COUNT) with
// PIN/PUK retry counting and lockout. An item is taken when start is high and
// busy is low. In the accept cycle the slot's rows are read from the two
// synchronous memories (flags/counters and PIN/PUK); in the next cycle (busy
// high) the codes are compared, counters and flags are updated and the rows
// written back. The result shows on res_o with valid_o high for exactly one
// cycle right after that; the receiver cannot stall it, and a new item may be
// started in that same cycle, so the block refuses new items only while busy
// is high, as the memories give their read data registered.
// Only one item is in flight, so a write never overlaps a read of the same
// slot. After reset every slot reads as not created with the uninitialized
// flag and zero counters (per-row written bits stand in for the memory
// reset); PIN and PUK are only read after a create has written them. A slot
// number of zero or above SLOT_COUNT answers wrong parameter with the
// uninitialized flag and changes nothing.
module pin_retry_lockout_table import prlt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [3:0]  SlotMax = 4'(SLOT_COUNT);

  // sequencer codes
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic accept;

  // registered item and memory read data
  cmd_t   cmd_q;
  meta_t  meta_mem [SLOT_COUNT];
  codes_t code_mem [SLOT_COUNT];
  meta_t  meta_rd_q;
  codes_t code_rd_q;

  // per-slot flops: created mark, and whether the meta row was ever written
  logic [SLOT_COUNT-1:0] slot_valid_q, slot_valid_d;
  logic [SLOT_COUNT-1:0] row_written_q, row_written_d;

  logic [3:0]      rd_sidx, ex_sidx;
  logic [IdxW-1:0] rd_idx, ex_idx;
  logic            slot_ok;

  meta_t  meta_cur, meta_d;
  codes_t code_d;
  logic   meta_we, code_we;
  logic [2:0] rc;
  logic [3:0] try_inc;

  res_t res_q, res_d;
  logic valid_q;

  assign accept = start && !busy;
  assign busy   = (state_q == StExec);

  // read address comes straight from the incoming item
  assign rd_sidx = cmd_i.slot - 4'd1;
  assign rd_idx  = rd_sidx[IdxW-1:0];
  assign ex_sidx = cmd_q.slot - 4'd1;
  assign ex_idx  = ex_sidx[IdxW-1:0];
  assign slot_ok = (cmd_q.slot != 4'd0) && (cmd_q.slot <= SlotMax);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StExec;
      StExec:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // unwritten rows read as the reset value
  assign meta_cur = row_written_q[ex_idx] ? meta_rd_q : MetaReset;

  // read-modify-write of the addressed slot
  always_comb begin
    meta_d        = meta_cur;
    code_d        = code_rd_q;
    meta_we       = 1'b0;
    code_we       = 1'b0;
    rc            = RcOk;
    slot_valid_d  = slot_valid_q;
    row_written_d = row_written_q;
    try_inc       = 4'd0;

    if (!slot_ok) begin
      rc = RcParam;
    end else if (cmd_q.op == OpCreate) begin
      meta_d = '{flags: 4'd0, pin_tries: 4'd0, pin_limit: cmd_q.pin_limit_in,
                 puk_tries: 4'd0, puk_limit: cmd_q.puk_limit_in};
      code_d = '{pin: cmd_q.code_a, puk: cmd_q.code_b};
      meta_we = 1'b1;
      code_we = 1'b1;
      slot_valid_d[ex_idx] = 1'b1;
    end else if (cmd_q.op == OpGetStat) begin
      rc = RcOk;
    end else if (cmd_q.op == OpSetStat) begin
      meta_d.flags = cmd_q.status_in;
      meta_we = 1'b1;
    end else if (!slot_valid_q[ex_idx]) begin
      rc = RcParam;
    end else if (cmd_q.op == OpUnblock) begin
      if (meta_cur.puk_tries >= meta_cur.puk_limit) begin
        rc = RcStatus;
      end else if (code_rd_q.puk == cmd_q.code_b) begin
        meta_d.puk_tries = 4'd0;
        meta_d.pin_tries = 4'd0;
        meta_d.flags[FlagBlockedBit] = 1'b0;
        code_d.pin = cmd_q.code_a;
        meta_we = 1'b1;
        code_we = 1'b1;
      end else begin
        try_inc = meta_cur.puk_tries + 4'd1;
        meta_d.puk_tries = try_inc;
        meta_we = 1'b1;
        if (meta_cur.puk_limit != 4'd0 && try_inc == meta_cur.puk_limit - 4'd1) begin
          rc = RcLast;
        end else begin
          rc = RcDenied;
        end
      end
    end else begin
      // verify, enable, disable, change
      if (meta_cur.pin_tries >= meta_cur.pin_limit) begin
        rc = RcStatus;
      end else if (code_rd_q.pin == cmd_q.code_a) begin
        meta_d.pin_tries = 4'd0;
        meta_we = 1'b1;
        case (cmd_q.op)
          OpVerify: meta_d.flags[FlagVerifiedBit] = 1'b1;
          OpEnable: begin
            meta_d.flags[FlagEnabledBit]  = 1'b1;
            meta_d.flags[FlagVerifiedBit] = 1'b0;
          end
          OpDisable: meta_d.flags[FlagEnabledBit] = 1'b0;
          default: begin
            code_d.pin = cmd_q.code_b;
            code_we = 1'b1;
          end
        endcase
      end else begin
        // wrong pin: count, warn on the last try, block at the limit
        try_inc = meta_cur.pin_tries + 4'd1;
        meta_d.pin_tries = try_inc;
        meta_we = 1'b1;
        if (meta_cur.pin_limit != 4'd0 && try_inc == meta_cur.pin_limit - 4'd1) begin
          rc = RcLast;
        end else if (try_inc >= meta_cur.pin_limit) begin
          meta_d.flags[FlagBlockedBit] = 1'b1;
          rc = RcStatus;
        end else begin
          rc = RcDenied;
        end
      end
    end

    if (meta_we) begin
      row_written_d[ex_idx] = 1'b1;
    end

    res_d.result_code = rc;
    res_d.status_out  = slot_ok ? meta_d.flags : FlagUninit;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      valid_q       <= 1'b0;
      slot_valid_q  <= '0;
      row_written_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= busy;
      if (busy) begin
        slot_valid_q  <= slot_valid_d;
        row_written_q <= row_written_d;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (busy) begin
      res_q <= res_d;
    end
  end

  // flags and counters memory
  always_ff @(posedge clk_i) begin
    if (busy && meta_we) begin
      meta_mem[ex_idx] <= meta_d;
    end
    if (accept) begin
      meta_rd_q <= meta_mem[rd_idx];
    end
  end

  // pin and puk memory
  always_ff @(posedge clk_i) begin
    if (busy && code_we) begin
      code_mem[ex_idx] <= code_d;
    end
    if (accept) begin
      code_rd_q <= code_mem[rd_idx];
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `PRLT_ASSERT(a_accept_goes_busy, accept |=> busy, "accepted item did not start work")
  `PRLT_ASSERT(a_busy_gives_result, busy |=> valid_o && !busy, "work cycle gave no result")
  `PRLT_ASSERT(a_result_not_busy, valid_o |-> !busy, "result shown while still working")
  `PRLT_ASSERT(a_rc_range, valid_o |-> res_o.result_code <= RcDenied, "result code out of range")
  `PRLT_ASSERT_RST(a_reset_quiet, !rst_ni |=> !busy && !valid_o, "activity right after reset")

endmodule

/* sim/pin_retry_lockout_table_tb.sv */
// testbench for the pin retry lockout table: directed and random commands
`timescale 1ns / 100ps

module pin_retry_lockout_table_tb;
  import prlt_pkg::*;

  localparam int unsigned SlotCount  = 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ShownMax   = 10;

  // fixed codes for the directed part
  localparam logic [CodeW-1:0] PinA    = 64'h0123_4567_89ab_cdef;
  localparam logic [CodeW-1:0] AllOnes = '1;
  localparam logic [CodeW-1:0] AllZero = '0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  cmd_t cmd_i  = '0;
  logic valid_o;
  res_t res_o;

  // predicted answers, oldest first
  res_t answer_q[$];

  // predicted card state, one entry per slot
  logic             card_created [SlotCount];
  logic [3:0]       card_flags   [SlotCount];
  logic [CodeW-1:0] card_pin     [SlotCount];
  logic [CodeW-1:0] card_puk     [SlotCount];
  logic [3:0]       card_pin_tries [SlotCount];
  logic [3:0]       card_pin_lim   [SlotCount];
  logic [3:0]       card_puk_tries [SlotCount];
  logic [3:0]       card_puk_lim   [SlotCount];

  // percentage of items preceded by sender idle cycles
  int unsigned idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned stall_cycles = 0;

  pin_retry_lockout_table #(
    .SLOT_COUNT(SlotCount)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // work out the answer of one accepted command and update the card state
  function automatic res_t predict_answer(cmd_t c);
    res_t        r;
    int unsigned s;
    int unsigned t;
    int unsigned lim;
    r.result_code = RcOk;
    r.status_out  = FlagUninit;
    // out-of-range slot touches nothing
    if (c.slot == 0 || c.slot > SlotCount) begin
      r.result_code = RcParam;
      return r;
    end
    s = c.slot - 1;
    case (c.op)
      OpCreate: begin
        card_created[s]   = 1'b1;
        card_flags[s]     = '0;
        card_pin[s]       = c.code_a;
        card_puk[s]       = c.code_b;
        card_pin_tries[s] = '0;
        card_pin_lim[s]   = c.pin_limit_in;
        card_puk_tries[s] = '0;
        card_puk_lim[s]   = c.puk_limit_in;
      end
      OpGetStat: ;
      OpSetStat: card_flags[s] = c.status_in;
      default: begin
        if (!card_created[s]) begin
          r.result_code = RcParam;
        end else if (c.op == OpUnblock) begin
          lim = card_puk_lim[s];
          if (card_puk_tries[s] >= card_puk_lim[s]) begin
            r.result_code = RcStatus;
          end else if (card_puk[s] == c.code_b) begin
            // good puk clears both counters and loads the new pin
            card_puk_tries[s] = '0;
            card_pin_tries[s] = '0;
            card_flags[s][FlagBlockedBit] = 1'b0;
            card_pin[s] = c.code_a;
          end else begin
            // wrong puk never blocks
            t = (card_puk_tries[s] + 1) % 16;
            card_puk_tries[s] = 4'(t);
            r.result_code = (lim >= 1 && t == lim - 1) ? RcLast : RcDenied;
          end
        end else begin
          lim = card_pin_lim[s];
          if (card_pin_tries[s] >= card_pin_lim[s]) begin
            r.result_code = RcStatus;
          end else if (card_pin[s] == c.code_a) begin
            card_pin_tries[s] = '0;
            case (c.op)
              OpVerify: card_flags[s][FlagVerifiedBit] = 1'b1;
              OpEnable: begin
                card_flags[s][FlagEnabledBit]  = 1'b1;
                card_flags[s][FlagVerifiedBit] = 1'b0;
              end
              OpDisable: card_flags[s][FlagEnabledBit] = 1'b0;
              default: card_pin[s] = c.code_b;
            endcase
          end else begin
            // wrong pin: last attempt, then block at the limit
            t = (card_pin_tries[s] + 1) % 16;
            card_pin_tries[s] = 4'(t);
            if (lim >= 1 && t == lim - 1) begin
              r.result_code = RcLast;
            end else if (t >= lim) begin
              card_flags[s][FlagBlockedBit] = 1'b1;
              r.result_code = RcStatus;
            end else begin
              r.result_code = RcDenied;
            end
          end
        end
      end
    endcase
    r.status_out = card_flags[s];
    return r;
  endfunction

  // present one item, hold it until taken, then record its answer
  task automatic issue_cmd(cmd_t c);
    // random sender gaps before the item
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    answer_q.push_back(predict_answer(c));
  endtask

  task automatic run_cmd(input logic [2:0] op, input logic [3:0] slot,
                         input logic [CodeW-1:0] a, input logic [CodeW-1:0] b,
                         input logic [3:0] plim, input logic [3:0] ulim,
                         input logic [3:0] st);
    cmd_t c;
    c = '{op: op, slot: slot, code_a: a, code_b: b, pin_limit_in: plim,
          puk_limit_in: ulim, status_in: st};
    issue_cmd(c);
  endtask

  // random code with the occasional extreme
  function automatic logic [CodeW-1:0] rand_code();
    case ($urandom_range(19))
      0: return AllZero;
      1: return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // retry limits: mostly small, sometimes zero or the maximum
  function automatic logic [3:0] rand_limit();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'($urandom_range(15));
      default: return 4'($urandom_range(6, 1));
    endcase
  endfunction

  // mostly well-formed traffic on created slots, with the right code often
  function automatic cmd_t make_random_cmd();
    cmd_t        c;
    int unsigned pick;
    int unsigned s;
    pick = $urandom_range(99);
    if (pick < 10) c.op = OpCreate;
    else if (pick < 35) c.op = OpVerify;
    else if (pick < 45) c.op = OpEnable;
    else if (pick < 55) c.op = OpDisable;
    else if (pick < 70) c.op = OpUnblock;
    else if (pick < 80) c.op = OpChange;
    else if (pick < 92) c.op = OpGetStat;
    else c.op = OpSetStat;
    if ($urandom_range(9) == 0) begin
      c.slot = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, SlotCount + 1));
    end else begin
      c.slot = 4'($urandom_range(SlotCount, 1));
    end
    c.code_a       = rand_code();
    c.code_b       = rand_code();
    c.pin_limit_in = rand_limit();
    c.puk_limit_in = rand_limit();
    c.status_in    = 4'($urandom_range(15));
    if (c.slot != 0 && c.slot <= SlotCount) begin
      s = c.slot - 1;
      if (card_created[s]) begin
        if ($urandom_range(99) < 60) c.code_a = card_pin[s];
        if ($urandom_range(99) < 60) c.code_b = card_puk[s];
      end
    end
    return c;
  endfunction

  // fresh table: everything answers as not created
  task automatic test_reset_state();
    run_cmd(OpGetStat, 4'd1, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpVerify,  4'd1, AllOnes, AllOnes, 4'd0, 4'd0, 4'd0);
    run_cmd(OpEnable,  4'd4, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpDisable, 4'd4, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpUnblock, 4'd4, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpChange,  4'd4, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
  endtask

  // slot zero and slots past the table
  task automatic test_bad_slots();
    run_cmd(OpVerify,  4'd0,  AllOnes, AllOnes, 4'd15, 4'd15, 4'd15);
    run_cmd(OpCreate,  4'd9,  AllOnes, AllOnes, 4'd15, 4'd15, 4'd15);
    run_cmd(OpSetStat, 4'd15, AllOnes, AllOnes, 4'd15, 4'd15, 4'd15);
  endtask

  // wrong pins down to the lock, a zero limit, maximum limits
  task automatic test_pin_lockout();
    run_cmd(OpCreate, 4'd1, PinA, AllOnes, 4'd3, 4'd2, 4'd0);
    run_cmd(OpVerify, 4'd1, ~PinA, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpVerify, 4'd1, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpVerify, 4'd1, AllOnes, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpVerify, 4'd1, PinA, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpCreate, 4'd8, AllOnes, AllZero, 4'd0, 4'd0, 4'd15);
    run_cmd(OpVerify, 4'd8, AllOnes, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpCreate, 4'd3, AllZero, AllOnes, 4'd15, 4'd15, 4'd0);
  endtask

  // puk path: wrong puk, unblock, unblock of an open slot, exhausted puk
  task automatic test_puk_unblock();
    run_cmd(OpUnblock, 4'd1, AllOnes, PinA, 4'd0, 4'd0, 4'd0);
    run_cmd(OpUnblock, 4'd1, AllZero, AllOnes, 4'd0, 4'd0, 4'd0);
    run_cmd(OpUnblock, 4'd1, AllZero, AllOnes, 4'd0, 4'd0, 4'd0);
    run_cmd(OpUnblock, 4'd8, PinA, AllZero, 4'd0, 4'd0, 4'd0);
  endtask

  // flag updates from good pins, pin change, raw status access
  task automatic test_flag_ops();
    run_cmd(OpVerify,  4'd1, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpEnable,  4'd1, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpDisable, 4'd1, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpChange,  4'd1, AllZero, AllOnes, 4'd0, 4'd0, 4'd0);
    run_cmd(OpVerify,  4'd1, AllOnes, AllZero, 4'd0, 4'd0, 4'd0);
    run_cmd(OpSetStat, 4'd2, AllZero, AllZero, 4'd0, 4'd0, 4'd15);
    run_cmd(OpGetStat, 4'd2, AllZero, AllZero, 4'd0, 4'd0, 4'd0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) issue_cmd(make_random_cmd());
  endtask

  // compare each answer with the oldest prediction
  always @(posedge clk_i) begin : check_answers
    res_t want;
    if (rst_ni && valid_o) begin
      if (answer_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ShownMax) begin
          $display("%0t: answer with none expected: rc %0d status %h",
                   $realtime, res_o.result_code, res_o.status_out);
        end
      end else begin
        want = answer_q.pop_front();
        if (res_o.result_code !== want.result_code ||
            res_o.status_out !== want.status_out) begin
          err_cnt++;
          if (err_cnt <= ShownMax) begin
            $display("%0t: mismatch: rc exp %0d got %0d, status exp %h got %h",
                     $realtime, want.result_code, res_o.result_code,
                     want.status_out, res_o.status_out);
          end
        end
      end
    end
  end

  // watchdog: too long with neither an item taken nor an answer given
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // predicted state after reset
    for (int i = 0; i < SlotCount; i++) begin
      card_created[i]   = 1'b0;
      card_flags[i]     = FlagUninit;
      card_pin[i]       = '0;
      card_puk[i]       = '0;
      card_pin_tries[i] = '0;
      card_pin_lim[i]   = '0;
      card_puk_tries[i] = '0;
      card_puk_lim[i]   = '0;
    end
    // hold reset at the start, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // light sender gaps for the directed part and first random phase
    idle_pct = 7;
    test_reset_state();
    test_bad_slots();
    test_pin_lockout();
    test_puk_unblock();
    test_flag_ops();
    test_random_traffic(380);
    // heavy sender gaps
    idle_pct = 47;
    test_random_traffic(380);
    // back to back
    idle_pct = 0;
    test_random_traffic(380);

    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/prlt_pkg.sv
rtl/core/pin_retry_lockout_table.sv
sim/pin_retry_lockout_table_tb.sv
